// ===== rtl/ksk_pkg.sv =====
// Shared types and constants of the knapsack solver: field widths, the queued
// item word and the back-end state encoding.
// No dependencies; every other file of the block imports this package.
package ksk_pkg;

  localparam int unsigned CAP_W    = 10;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned BEST_W   = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 10'd1023;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [VALUE_W-1:0]  value;
    logic                last;
    logic [CAP_W-1:0]    cap;
  } item_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SWEEP,
    BK_DRAIN,
    BK_RESULT
  } back_state_e;

endpackage

// ===== rtl/ksk_front.sv =====
// Front end: capacity register, input handshake and item classification.
// Depends on ksk_pkg; feeds ksk_queue.
module ksk_front #(
  parameter int unsigned MAX_CAPACITY = 1023
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ksk_pkg::CAP_W-1:0]    cfg_capacity_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ksk_pkg::WEIGHT_W-1:0] item_weight_i,
  input  logic [ksk_pkg::VALUE_W-1:0]  item_value_i,
  input  logic                         last_item_i,
  input  logic                         init_done_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output ksk_pkg::item_t               item_o
);
  import ksk_pkg::*;

  logic [CAP_W-1:0] capacity_q;
  logic [CAP_W-1:0] capacity_d;
  logic [CAP_W-1:0] eff_cap;
  logic             heavy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  always_comb begin
    capacity_d = capacity_q;
    if (cfg_valid_i && cfg_ready_o) begin
      capacity_d = cfg_capacity_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (int'(capacity_q) > int'(MAX_CAPACITY)) begin
      eff_cap = CAP_W'(MAX_CAPACITY);
    end else begin
      eff_cap = capacity_q;
    end
  end

  // An item that fits nowhere and does not close the problem leaves the table unchanged.
  assign heavy      = item_weight_i > eff_cap;
  assign in_ready_o = init_done_i && !q_full_i;
  assign push_o     = in_valid_i && in_ready_o && (last_item_i || !heavy);

  assign item_o.weight = item_weight_i;
  assign item_o.value  = item_value_i;
  assign item_o.last   = last_item_i;
  assign item_o.cap    = eff_cap;

endmodule

// ===== rtl/ksk_queue.sv =====
// Short item queue between the front end and the sweep engine.
// Depends on ksk_pkg for the item word and depth.
module ksk_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ksk_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ksk_pkg::item_t item_o
);
  import ksk_pkg::*;

  item_t             entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/ksk_back.sv =====
// Sweep engine: value table memory, downward capacity sweep, result register
// and the table clearing pass. Depends on ksk_pkg; fed by ksk_queue.
module ksk_back #(
  parameter int unsigned MAX_CAPACITY = 1023
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  ksk_pkg::item_t             q_item_i,
  output logic                       pop_o,
  output logic                       init_done_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ksk_pkg::BEST_W-1:0] best_value_o
);
  import ksk_pkg::*;

  localparam int unsigned DEPTH = MAX_CAPACITY + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [BEST_W-1:0] table_mem [DEPTH];

  back_state_e       state_q, state_d;
  logic [CAP_W-1:0]  c_q, c_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              init_done_q, init_done_d;
  logic              out_valid_q, out_valid_d;
  item_t             item_q;
  logic              s1_valid_q;
  logic              s1_fit_q;
  logic [CAP_W-1:0]  s1_c_q;
  logic [BEST_W-1:0] rd_a_q;
  logic [BEST_W-1:0] rd_b_q;
  logic [BEST_W-1:0] result_q;
  logic [BEST_W-1:0] best_q;

  logic              rd_en;
  logic              load_out;
  logic              fit;
  logic [CAP_W-1:0]  diff;
  logic [BEST_W:0]   sum;
  logic [BEST_W-1:0] take;
  logic              upd;
  logic [BEST_W-1:0] newval;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BEST_W-1:0] mem_wdata;

  assign fit  = item_q.weight <= c_q;
  assign diff = c_q - item_q.weight;
  assign sum  = {1'b0, rd_b_q} + (BEST_W + 1)'(item_q.value);
  assign take = sum[BEST_W] ? '1 : sum[BEST_W-1:0];
  assign upd  = s1_valid_q && s1_fit_q && (take > rd_a_q);
  assign newval = upd ? take : rd_a_q;

  assign mem_we    = (state_q == BK_CLEAR) || upd;
  assign mem_waddr = (state_q == BK_CLEAR) ? clr_q : AW'(s1_c_q);
  assign mem_wdata = (state_q == BK_CLEAR) ? '0 : take;

  always_comb begin
    state_d     = state_q;
    c_d         = c_q;
    clr_d       = clr_q;
    init_done_d = init_done_q;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        if (clr_q == AW'(MAX_CAPACITY)) begin
          init_done_d = 1'b1;
          state_d     = BK_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          c_d     = q_item_i.cap;
          state_d = BK_SWEEP;
        end
      end
      BK_SWEEP: begin
        rd_en = 1'b1;
        if (c_q == '0) begin
          state_d = BK_DRAIN;
        end else begin
          c_d = c_q - 1'b1;
        end
      end
      BK_DRAIN: begin
        state_d = item_q.last ? BK_RESULT : BK_IDLE;
      end
      BK_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          clr_d    = '0;
          state_d  = BK_CLEAR;
        end
      end
      default: begin
        state_d = BK_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      c_q         <= '0;
      clr_q       <= '0;
      init_done_q <= 1'b0;
      out_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      c_q         <= c_d;
      clr_q       <= clr_d;
      init_done_q <= init_done_d;
      out_valid_q <= out_valid_d;
      s1_valid_q  <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_item_i;
    end
    if (rd_en) begin
      s1_fit_q <= fit;
      s1_c_q   <= c_q;
    end
    if (s1_valid_q && item_q.last && (s1_c_q == item_q.cap)) begin
      result_q <= newval;
    end
    if (load_out) begin
      best_q <= result_q;
    end
  end

  // Reads always sit strictly below the pending write address, so the ports never collide.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_q <= table_mem[AW'(c_q)];
      rd_b_q <= table_mem[AW'(diff)];
    end
  end

  assign init_done_o  = init_done_q;
  assign out_valid_o  = out_valid_q;
  assign best_value_o = best_q;

endmodule

// ===== rtl/knapsack_01_dp_engine.sv =====
// Each queued item is swept from its capacity down to zero in the sweep engine, one table
// entry per cycle through the two read ports of the table memory; an item that fits nowhere
// and is not last is dropped at the input. A last item adds a result state, which waits for
// the output register to be free, and a clearing pass over the MAX_CAPACITY + 1 entries.
// After reset the table is cleared with in_ready_o low, and capacity is 1023. Depends on
// ksk_pkg, ksk_front, ksk_queue and ksk_back.
module knapsack_01_dp_engine #(
  parameter int unsigned MAX_CAPACITY = 1023
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ksk_pkg::CAP_W-1:0]    cfg_capacity_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ksk_pkg::WEIGHT_W-1:0] item_weight_i,
  input  logic [ksk_pkg::VALUE_W-1:0]  item_value_i,
  input  logic                         last_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ksk_pkg::BEST_W-1:0]   best_value_o
);
  import ksk_pkg::*;

  logic  init_done;
  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  ksk_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_capacity_i(cfg_capacity_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .item_weight_i (item_weight_i),
    .item_value_i  (item_value_i),
    .last_item_i   (last_item_i),
    .init_done_i   (init_done),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  ksk_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  ksk_back #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .best_value_o(best_value_o)
  );

endmodule

// ===== rtl/ksk_checker.sv =====
// Port-level checks of the knapsack solver and the bind that attaches them.
// Depends on ksk_pkg and the top level knapsack_01_dp_engine.
module ksk_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       last_item_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [ksk_pkg::BEST_W-1:0] best_value_o
);
  import ksk_pkg::*;

  logic [2:0] pending_q, pending_d;
  logic       last_in;
  logic       word_out;

  assign last_in  = in_valid_i && in_ready_o && last_item_i;
  assign word_out = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (last_in && !word_out) begin
      pending_d = pending_q + 1'b1;
    end else if (word_out && !last_in) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_value_o))
    else $error("result word changed or dropped while stalled");

  a_out_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result word without a preceding last item");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more open problems than the block can hold");

  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input accepted before the table was cleared");

endmodule

bind knapsack_01_dp_engine ksk_checker u_ksk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_item_i (last_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .best_value_o(best_value_o)
);
